// ===== hw/rtl/gmti_pkg.sv =====
// Package for the grid mesh triangle indexer.
// Holds payload and internal struct types, register codes and width constants.
// No dependencies.
package gmti_pkg;

    localparam int VW     = 15;  // vertex index width
    localparam int DW     = 7;   // grid dimension width
    localparam int CW     = 6;   // cell coordinate width
    localparam int LW     = 3;   // level width
    localparam int NEdge  = 8;   // fan edges around a cell
    localparam int NLeftW = 4;   // edge counter width, holds NEdge

    // configuration register codes
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_DETAIL      = 2'd2,
        CFG_MIN_DETAIL  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CW-1:0] cell_row;
        logic [CW-1:0] cell_col;
    } t_cell;

    typedef struct packed {
        logic [VW-1:0] vertex_first;
        logic [VW-1:0] vertex_second;
        logic [VW-1:0] vertex_third;
        logic          final_triangle;
    } t_tri;

    // clamped configuration and vertex block bases
    typedef struct packed {
        logic [DW-1:0] w;
        logic [DW-1:0] h;
        logic [LW-1:0] lvl;
        logic [VW-1:0] p1;
        logic [VW-1:0] p2;
        logic [VW-1:0] p3;
        logic [VW-1:0] p4;
        logic [VW-1:0] p5;
        logic [VW-1:0] rb_base;
        logic [VW-1:0] bb_base;
    } t_cfg;

    // perimeter of one cell: base points, optional split points, centre
    typedef struct packed {
        logic                       valid;
        logic [NEdge:0][VW-1:0]     b;
        logic [NEdge-1:0][VW-1:0]   s;
        logic [NEdge-1:0]           sp;
        logic [VW-1:0]              ctr;
        logic [NLeftW-1:0]          left;
    } t_ring;

endpackage

// ===== hw/rtl/gmti_setup.sv =====
// Configuration registers and the vertex block bases derived from them.
// Depends on gmti_pkg.
module gmti_setup
    import gmti_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [DW-1:0] i_cfg_data,
    output t_cfg          o_cfg
);

    localparam logic [DW-1:0] MaxDim = DW'(MAX_DIM);

    logic [DW-1:0] r_width, n_width;
    logic [DW-1:0] r_height, n_height;
    logic [LW-1:0] r_detail, n_detail;
    logic [LW-1:0] r_min_detail, n_min_detail;
    logic [DW-1:0] n_w, n_h;
    logic [VW-1:0] n_wh, n_p2, n_p3, n_p4, n_p5, n_rbb, n_bbb;
    logic [VW-1:0] n_wx, n_hx;
    logic [VW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_rbb, r_bbb;
    logic [DW-1:0] w_clamp, h_clamp;

    // register writes, reset folded in so the bases follow at once
    always_comb begin
        n_width      = r_width;
        n_height     = r_height;
        n_detail     = r_detail;
        n_min_detail = r_min_detail;
        if (!i_rst_n) begin
            n_width      = DW'(2);
            n_height     = DW'(2);
            n_detail     = '0;
            n_min_detail = '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_WIDTH:  n_width      = i_cfg_data;
                CFG_GRID_HEIGHT: n_height     = i_cfg_data;
                CFG_DETAIL:      n_detail     = i_cfg_data[LW-1:0];
                CFG_MIN_DETAIL:  n_min_detail = i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // bases of the vertex blocks from the next configuration, each in closed form
    always_comb begin
        n_w   = (n_width  > MaxDim) ? MaxDim : n_width;
        n_h   = (n_height > MaxDim) ? MaxDim : n_height;
        n_wx  = VW'(n_w);
        n_hx  = VW'(n_h);
        n_wh  = VW'(n_wx * n_hx);
        n_p2  = VW'((n_wh << 1) - n_wx - n_hx + VW'(1));
        n_p3  = VW'((n_wh << 1) + n_wh - n_wx - (n_hx << 1) + VW'(1));
        n_p4  = VW'((n_wh << 2) - (n_wx << 1) - (n_hx << 1) + VW'(1));
        n_p5  = VW'((n_wh << 2) + (n_wx << 1) - (n_hx << 1) - VW'(3));
        n_rbb = VW'((n_wh << 2) + (n_wx << 1) - VW'(5));
        n_bbb = VW'((n_wh << 2) - (n_hx << 1) - VW'(1));
    end

    always_ff @(posedge i_clk) begin
        r_width      <= n_width;
        r_height     <= n_height;
        r_detail     <= n_detail;
        r_min_detail <= n_min_detail;
        r_p1         <= n_wh;
        r_p2         <= n_p2;
        r_p3         <= n_p3;
        r_p4         <= n_p4;
        r_p5         <= n_p5;
        r_rbb        <= n_rbb;
        r_bbb        <= n_bbb;
    end

    // clamped view for the cell stage
    always_comb begin
        w_clamp       = (r_width  > MaxDim) ? MaxDim : r_width;
        h_clamp       = (r_height > MaxDim) ? MaxDim : r_height;
        o_cfg.w       = w_clamp;
        o_cfg.h       = h_clamp;
        o_cfg.lvl     = (r_detail > r_min_detail) ? r_detail : r_min_detail;
        o_cfg.p1      = r_p1;
        o_cfg.p2      = r_p2;
        o_cfg.p3      = r_p3;
        o_cfg.p4      = r_p4;
        o_cfg.p5      = r_p5;
        o_cfg.rb_base = r_rbb;
        o_cfg.bb_base = r_bbb;
    end

endmodule

// ===== hw/rtl/gmti_cell.sv =====
// Cell input register and perimeter index computation for one cell.
// Depends on gmti_pkg.
module gmti_cell
    import gmti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_take,
    input  t_cell i_cell,
    input  t_cfg  i_cfg,
    output logic  o_pend,
    output t_ring o_ring
);

    logic          r_pend;
    logic [CW-1:0] r_row, r_col;
    logic [VW-1:0] iw, ul, ur, ll, lr, ctr, hm1, hm2, vm1, vm2;
    logic [VW-1:0] ix, jx, wx, rb, bb, lb;
    logic          in_grid, coarse, split, top, bot, lft, rgt;

    // cell holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_accept) begin
            r_pend <= 1'b1;
        end else if (i_take) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row <= i_cell.cell_row;
            r_col <= i_cell.cell_col;
        end
    end

    assign o_pend = r_pend;

    // corner and midpoint indices
    always_comb begin
        ix  = VW'(r_row);
        jx  = VW'(r_col);
        wx  = VW'(i_cfg.w);
        iw  = VW'(ix * wx);
        ul  = VW'(iw + jx);
        ur  = VW'(ul + VW'(1));
        ll  = VW'(ul + wx);
        lr  = VW'(ll + VW'(1));
        ctr = VW'(i_cfg.p1 + ul - ix);
        hm1 = VW'(i_cfg.p2 + ul - ix);
        hm2 = VW'(hm1 + wx - VW'(1));
        vm1 = VW'(i_cfg.p3 + ul);
        vm2 = VW'(vm1 + VW'(1));
        rb  = VW'(i_cfg.rb_base + (ix << 1));
        bb  = VW'(i_cfg.bb_base + (jx << 1));
        lb  = VW'(i_cfg.p5 + (ix << 1));
    end

    // range check and border flags
    always_comb begin
        in_grid = (i_cfg.w >= DW'(2)) && (i_cfg.h >= DW'(2))
                  && (DW'(r_row) < DW'(i_cfg.h - DW'(1)))
                  && (DW'(r_col) < DW'(i_cfg.w - DW'(1)));
        coarse  = (i_cfg.lvl[LW-1:1] != '0);
        split   = (i_cfg.lvl == '0);
        top     = split && (r_row == '0);
        bot     = split && (DW'(r_row) == DW'(i_cfg.h - DW'(2)));
        lft     = split && (r_col == '0);
        rgt     = split && (DW'(r_col) == DW'(i_cfg.w - DW'(2)));
    end

    // perimeter walk, clockwise from the upper left corner; coarse levels fan around that corner
    always_comb begin
        o_ring       = '0;
        o_ring.valid = r_pend && in_grid;
        if (coarse) begin
            o_ring.b[0] = ur;
            o_ring.b[1] = lr;
            o_ring.b[2] = ll;
            o_ring.ctr  = ul;
            o_ring.left = NLeftW'(2);
        end else begin
            o_ring.b[0] = ul;
            o_ring.b[1] = hm1;
            o_ring.b[2] = ur;
            o_ring.b[3] = vm2;
            o_ring.b[4] = lr;
            o_ring.b[5] = hm2;
            o_ring.b[6] = ll;
            o_ring.b[7] = vm1;
            o_ring.b[8] = ul;
            o_ring.s[0] = VW'(i_cfg.p4 + (jx << 1));
            o_ring.s[1] = VW'(i_cfg.p4 + (jx << 1) + VW'(1));
            o_ring.s[2] = rb;
            o_ring.s[3] = VW'(rb + VW'(1));
            o_ring.s[4] = VW'(bb + VW'(1));
            o_ring.s[5] = bb;
            o_ring.s[6] = VW'(lb + VW'(1));
            o_ring.s[7] = lb;
            o_ring.sp   = {lft, lft, bot, bot, rgt, rgt, top, top};
            o_ring.ctr  = ctr;
            o_ring.left = NLeftW'(NEdge);
        end
    end

endmodule

// ===== hw/rtl/gmti_emit.sv =====
// Triangle emitter: walks the loaded perimeter one triangle per cycle.
// Depends on gmti_pkg.
module gmti_emit
    import gmti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_ring i_ring,
    output logic  o_free,
    output logic  o_tri_valid,
    output t_tri  o_tri
);

    logic                     r_act, n_act;
    logic                     r_half, n_half;
    logic [NLeftW-1:0]        r_left, n_left;
    logic [NEdge:0][VW-1:0]   r_b, n_b;
    logic [NEdge-1:0][VW-1:0] r_s, n_s;
    logic [NEdge-1:0]         r_sp, n_sp;
    logic [VW-1:0]            r_ctr, n_ctr;
    logic                     adv, last;

    // edge finishes when unsplit or on its second half
    assign adv  = !r_sp[0] || r_half;
    assign last = r_act && adv && (r_left == NLeftW'(1));

    assign o_free = !r_act || last;

    // next state: load, stop after the last edge, advance along the ring or take the second half
    always_comb begin
        n_act  = r_act;
        n_half = r_half;
        n_left = r_left;
        n_b    = r_b;
        n_s    = r_s;
        n_sp   = r_sp;
        n_ctr  = r_ctr;
        if (i_load && i_ring.valid) begin
            n_act  = 1'b1;
            n_half = 1'b0;
            n_left = i_ring.left;
            n_b    = i_ring.b;
            n_s    = i_ring.s;
            n_sp   = i_ring.sp;
            n_ctr  = i_ring.ctr;
        end else if (last) begin
            n_act = 1'b0;
        end else if (r_act) begin
            if (adv) begin
                n_half = 1'b0;
                n_left = NLeftW'(r_left - NLeftW'(1));
                n_b    = {VW'(0), r_b[NEdge:1]};
                n_s    = {VW'(0), r_s[NEdge-1:1]};
                n_sp   = {1'b0, r_sp[NEdge-1:1]};
            end else begin
                n_half = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_half <= 1'b0;
            r_left <= '0;
        end else begin
            r_act  <= n_act;
            r_half <= n_half;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_s   <= n_s;
        r_sp  <= n_sp;
        r_ctr <= n_ctr;
    end

    // current triangle from the head of the ring
    always_comb begin
        o_tri_valid          = r_act;
        o_tri.vertex_first   = (r_sp[0] && r_half) ? r_s[0] : r_b[0];
        o_tri.vertex_second  = r_ctr;
        o_tri.vertex_third   = (r_sp[0] && !r_half) ? r_s[0] : r_b[1];
        o_tri.final_triangle = last;
    end

endmodule

// ===== hw/rtl/grid_mesh_triangle_indexer.sv =====
// Top level of the grid mesh triangle indexer.
// Depends on gmti_pkg, gmti_setup, gmti_cell and gmti_emit.
//
// One cell is taken when start is high and busy is low; its triangles leave
// on o_tri, one per cycle, each marked by o_tri_valid for a single cycle, and
// the last one carries final_triangle. The receiver cannot stall the output.
// A cell yields 8 triangles at level 1, 8 to 16 at level 0 (two more for
// each border edge it touches) and 2 at level 2 and above; the single
// triangle output sets the rate. The first triangle appears once the cell
// has passed the holding register and been loaded into the emitter, and
// the next held cell enters the emitter while the last triangle is out,
// so cells follow one another with no gap. A cell outside the grid, or any
// cell of a grid narrower than two, gives no triangle and is dropped once
// the emitter is free. Configuration writes are always ready; the user must
// make them only while no cell is in flight; the block does not enforce it.
module grid_mesh_triangle_indexer
    import gmti_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_cell         i_cell,
    output logic          o_tri_valid,
    output t_tri          o_tri,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [DW-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_ring ring;
    logic  pend, emit_free, accept, take;

    // cell transfer into the holding stage and on to the emitter
    assign take        = pend && emit_free;
    assign busy        = pend && !emit_free;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    gmti_setup #(
        .MAX_DIM (MAX_DIM)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gmti_cell u_cell (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_take   (take),
        .i_cell   (i_cell),
        .i_cfg    (cfg),
        .o_pend   (pend),
        .o_ring   (ring)
    );

    gmti_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_ring      (ring),
        .o_free      (emit_free),
        .o_tri_valid (o_tri_valid),
        .o_tri       (o_tri)
    );

endmodule

// ===== sim/grid_mesh_triangle_indexer_test.sv =====
// Self-checking testbench for grid_mesh_triangle_indexer: drives cells, predicts each triangle.
// Depends on gmti_pkg and the grid_mesh_triangle_indexer RTL; reads no file.
module grid_mesh_triangle_indexer_test;
    import gmti_pkg::*;

    localparam int GRID_MAX      = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RAND_PHASES   = 12;
    localparam int CELLS_PER_PH  = 40;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_cell         i_cell = '0;
    logic          o_tri_valid;
    t_tri          o_tri;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [DW-1:0] i_cfg_data = '0;

    // shadow copy of the grid registers, reset values
    logic [DW-1:0] grid_w_reg = DW'(2);
    logic [DW-1:0] grid_h_reg = DW'(2);
    logic [LW-1:0] detail_reg = '0;
    logic [LW-1:0] min_detail_reg = '0;

    t_cell pending_cells[$];
    t_tri  expected_tris[$];
    int    cells_queued = 0;
    int    cells_taken = 0;
    int    gap_pct = 0;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    grid_mesh_triangle_indexer #(.MAX_DIM(GRID_MAX)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cell      (i_cell),
        .o_tri_valid (o_tri_valid),
        .o_tri       (o_tri),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // triangles of one cell under the current register settings
    function automatic void push_cell_triangles(t_cell c);
        int unsigned w, h, i, j, lvl;
        int unsigned p1, p2, p3, p4, p5;
        int unsigned ctr, ul, ur, ll, lr, hm1, hm2, vm1, vm2, rb, bb;
        int unsigned ring[17];
        int          nr;
        bit          split, top, bot, lft, rgt;
        t_tri        t;
        w = (grid_w_reg > GRID_MAX) ? GRID_MAX : grid_w_reg;
        h = (grid_h_reg > GRID_MAX) ? GRID_MAX : grid_h_reg;
        i = c.cell_row;
        j = c.cell_col;
        if (w < 2 || h < 2) return;
        if (i >= h - 1 || j >= w - 1) return;
        lvl = (detail_reg > min_detail_reg) ? detail_reg : min_detail_reg;
        ul = i * w + j;
        ur = ul + 1;
        ll = ul + w;
        lr = ll + 1;
        nr = 0;
        if (lvl >= 2) begin
            // coarse level: two triangles sharing the upper-left corner
            ctr = ul;
            ring[0] = ur;
            ring[1] = lr;
            ring[2] = ll;
            nr = 3;
        end else begin
            p1 = w * h;
            p2 = p1 + (w - 1) * (h - 1);
            p3 = p2 + (w - 1) * h;
            p4 = p3 + w * (h - 1);
            p5 = p4 + 4 * (w - 1);
            ctr = p1 + i * (w - 1) + j;
            hm1 = p2 + i * (w - 1) + j;
            hm2 = hm1 + (w - 1);
            vm1 = p3 + i * w + j;
            vm2 = vm1 + 1;
            split = (lvl == 0);
            top = split && i == 0;
            bot = split && i == h - 2;
            lft = split && j == 0;
            rgt = split && j == w - 2;
            rb = p5 + 2 * (h - 1) + 2 * i;
            bb = p4 + 2 * (w - 1) + 2 * j;
            // walk the perimeter, border points inserted where split
            ring[nr++] = ul;
            if (top) ring[nr++] = p4 + 2 * j;
            ring[nr++] = hm1;
            if (top) ring[nr++] = p4 + 2 * j + 1;
            ring[nr++] = ur;
            if (rgt) ring[nr++] = rb;
            ring[nr++] = vm2;
            if (rgt) ring[nr++] = rb + 1;
            ring[nr++] = lr;
            if (bot) ring[nr++] = bb + 1;
            ring[nr++] = hm2;
            if (bot) ring[nr++] = bb;
            ring[nr++] = ll;
            if (lft) ring[nr++] = p5 + 2 * i + 1;
            ring[nr++] = vm1;
            if (lft) ring[nr++] = p5 + 2 * i;
            ring[nr++] = ul;
        end
        for (int k = 0; k + 1 < nr; k++) begin
            t.vertex_first   = VW'(ring[k]);
            t.vertex_second  = VW'(ctr);
            t.vertex_third   = VW'(ring[k + 1]);
            t.final_triangle = (k + 2 == nr);
            expected_tris.push_back(t);
        end
    endfunction

    // cell driver: takes the next pending cell unless a random gap is due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                push_cell_triangles(i_cell);
                cells_taken++;
            end
            if (!(start && busy)) begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    start  <= 1'b1;
                    i_cell <= pending_cells.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // triangle monitor: every strobed triangle against the oldest expectation
    always @(posedge i_clk) begin
        t_tri exp_tri;
        if (i_rst_n && o_tri_valid) begin
            if (expected_tris.size() == 0) begin
                $error("unexpected triangle %0d %0d %0d final %0d", o_tri.vertex_first,
                       o_tri.vertex_second, o_tri.vertex_third, o_tri.final_triangle);
                mismatches++;
            end else begin
                exp_tri = expected_tris.pop_front();
                if (o_tri.vertex_first !== exp_tri.vertex_first) begin
                    $error("vertex_first expected %0d got %0d",
                           exp_tri.vertex_first, o_tri.vertex_first);
                    mismatches++;
                end
                if (o_tri.vertex_second !== exp_tri.vertex_second) begin
                    $error("vertex_second expected %0d got %0d",
                           exp_tri.vertex_second, o_tri.vertex_second);
                    mismatches++;
                end
                if (o_tri.vertex_third !== exp_tri.vertex_third) begin
                    $error("vertex_third expected %0d got %0d",
                           exp_tri.vertex_third, o_tri.vertex_third);
                    mismatches++;
                end
                if (o_tri.final_triangle !== exp_tri.final_triangle) begin
                    $error("final_triangle expected %0d got %0d",
                           exp_tri.final_triangle, o_tri.final_triangle);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_tri_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_cell(input int row, input int col);
        t_cell c;
        c.cell_row = CW'(row);
        c.cell_col = CW'(col);
        pending_cells.push_back(c);
        cells_queued++;
    endtask

    // wait until every cell is taken and every triangle has come out
    task automatic settle();
        while (cells_taken != cells_queued || expected_tris.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four grid registers back to back once the block is idle
    task automatic program_grid(input logic [DW-1:0] w, input logic [DW-1:0] h,
                                input logic [LW-1:0] det, input logic [LW-1:0] mind);
        t_cfg_reg      idx[4];
        logic [DW-1:0] val[4];
        idx = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_DETAIL, CFG_MIN_DETAIL};
        val = '{w, h, DW'(det), DW'(mind)};
        settle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_GRID_WIDTH:  grid_w_reg = val[k];
                CFG_GRID_HEIGHT: grid_h_reg = val[k];
                CFG_DETAIL:      detail_reg = val[k][LW-1:0];
                CFG_MIN_DETAIL:  min_detail_reg = val[k][LW-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int            wq, hq, row, col;
        logic [DW-1:0] rw, rh;
        logic [LW-1:0] rd, rm;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid of 2 by 2: the only cell touches all four borders
        queue_cell(0, 0);
        queue_cell(1, 0);
        queue_cell(0, 1);
        queue_cell(63, 63);

        // full-size grid, corners and border splits at the finest level
        program_grid(DW'(64), DW'(64), 3'd0, 3'd0);
        queue_cell(0, 0);
        queue_cell(0, 62);
        queue_cell(62, 0);
        queue_cell(62, 62);
        queue_cell(31, 33);
        queue_cell(42, 21);
        queue_cell(62, 63);
        queue_cell(63, 5);

        // oversized registers saturate, fan without splitting
        program_grid(DW'(127), DW'(100), 3'd1, 3'd0);
        queue_cell(0, 0);
        queue_cell(62, 62);
        queue_cell(17, 40);

        // minimum level raises the request
        program_grid(DW'(2), DW'(2), 3'd0, 3'd1);
        queue_cell(0, 0);

        // narrow grids give nothing
        program_grid(DW'(1), DW'(5), 3'd0, 3'd0);
        queue_cell(0, 0);
        program_grid(DW'(5), DW'(0), 3'd0, 3'd0);
        queue_cell(0, 0);

        // coarse level from either register
        program_grid(DW'(9), DW'(7), 3'd0, 3'd7);
        queue_cell(3, 4);
        program_grid(DW'(9), DW'(7), 3'd7, 3'd0);
        queue_cell(0, 0);
        program_grid(DW'(9), DW'(7), 3'd2, 3'd1);
        queue_cell(5, 7);

        // random phases, gap rate cycling through the idling modes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            rw = ($urandom_range(99) < 75) ? DW'($urandom_range(2, 12)) : DW'($urandom_range(0, 127));
            rh = ($urandom_range(99) < 75) ? DW'($urandom_range(2, 12)) : DW'($urandom_range(0, 127));
            rd = $urandom_range(1) ? LW'($urandom_range(0, 1)) : LW'($urandom_range(0, 7));
            rm = ($urandom_range(99) < 60) ? '0 : LW'($urandom_range(0, 7));
            program_grid(rw, rh, rd, rm);
            case (ph % 4)
                0: gap_pct = 0;
                1: gap_pct = 59;
                2: gap_pct = 0;
                default: gap_pct = 17;
            endcase
            wq = (rw > GRID_MAX) ? GRID_MAX : rw;
            hq = (rh > GRID_MAX) ? GRID_MAX : rh;
            for (int n = 0; n < CELLS_PER_PH; n++) begin
                if (wq >= 2 && hq >= 2 && $urandom_range(99) < 85) begin
                    row = $urandom_range(0, hq - 2);
                    col = $urandom_range(0, wq - 2);
                end else begin
                    row = $urandom_range(0, 63);
                    col = $urandom_range(0, 63);
                end
                queue_cell(row, col);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
